@@ design/xbrd_pkg.sv @@
// shared types and constants for the bounded random draw core
`timescale 1ns / 1ps
package xbrd_pkg;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
	localparam logic [63:0] PERCENT_SPAN = 64'd100;

	typedef enum logic [1:0] {
		REQ_RAW     = 2'd0,
		REQ_BELOW   = 2'd1,
		REQ_RANGE   = 2'd2,
		REQ_PERCENT = 2'd3
	} req_kind_t;

	// register indexes
	localparam logic [0:0] REG_SEED = 1'b0;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] count;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic signed [31:0] percent;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        raw_word;
		logic signed [31:0] int_value;
		logic               chance_hit;
		logic               invalid_arg;
	} out_item_t;

	// classified job from the front part to the back part
	typedef struct packed {
		logic        draw;       // needs a word from the generator
		logic        bounded;    // rejection and modulo needed
		logic        pct;        // compare result against percent
		logic [63:0] bound;      // modulo bound when bounded
		logic [31:0] offset;     // added to the remainder
		logic [31:0] pct_val;    // percent for the compare
		logic        hit;        // fixed hit when no draw
		logic        bad;        // invalid argument
	} job_t;

endpackage

@@ design/xoshiro_bounded_random_draw_core.sv @@
// top level of the bounded random draw core
`timescale 1ns / 1ps
// Serves one request at a time from a xoshiro256** generator. A raw request
// draws one word. Bounded requests first run a bit-serial remainder to find
// the rejection limit, then draw words until one is kept, then run another
// bit-serial remainder for the result. Invalid arguments and percent values
// outside 1..99 finish without a draw. After reset and after each seed write,
// seeding runs (each splitmix multiply works in 16-bit slices) before requests
// are served. A two-entry queue sits between the request classifier and the
// generator, and the result register lets the generator start the next
// request while a result beat waits.
module xoshiro_bounded_random_draw_core
	import xbrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [31:0] seed_q;
	logic        seed_wr;
	logic        job_valid;
	logic        job_take;
	job_t        job_data;

	// register port
	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && (paddr[1:0] == {REG_SEED, 1'b0});
	assign prdata  = (paddr == {REG_SEED, 1'b0}) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (seed_wr) begin
			seed_q <= pwdata;
		end
	end

	xbrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job_data  (job_data)
	);

	xbrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_wr   (seed_wr),
		.seed_val  (pwdata),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job_data  (job_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ design/xbrd_front.sv @@
// front part: classifies requests into jobs and queues them
`timescale 1ns / 1ps
module xbrd_front
	import xbrd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_take,
	output job_t     job_data
);

	job_t        cls;
	job_t        q_mem_q [2];
	logic [1:0]  cnt_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic        push;
	logic        pop;
	logic [63:0] lo64;
	logic [63:0] hi64;

	// classify one request
	always_comb begin
		lo64 = {{32{in_data.range_low[31]}}, in_data.range_low};
		hi64 = {{32{in_data.range_high[31]}}, in_data.range_high};
		cls = '0;
		unique case (req_kind_t'(in_data.req_type))
			REQ_RAW: begin
				cls.draw = 1'b1;
			end
			REQ_BELOW: begin
				if (in_data.count <= 0) begin
					cls.bad = 1'b1;
				end else begin
					cls.draw = 1'b1;
					cls.bounded = 1'b1;
					cls.bound = {32'd0, in_data.count};
				end
			end
			REQ_RANGE: begin
				if (in_data.range_low > in_data.range_high) begin
					cls.bad = 1'b1;
				end else begin
					cls.draw = 1'b1;
					cls.bounded = 1'b1;
					cls.bound = hi64 - lo64 + 64'd1;
					cls.offset = in_data.range_low;
				end
			end
			default: begin
				if (in_data.percent >= 100) begin
					cls.hit = 1'b1;
				end else if (in_data.percent > 0) begin
					cls.draw = 1'b1;
					cls.bounded = 1'b1;
					cls.pct = 1'b1;
					cls.bound = PERCENT_SPAN;
					cls.pct_val = in_data.percent;
				end
			end
		endcase
	end

	// two-entry queue
	assign in_stall  = cnt_q[1];
	assign push      = in_valid && !in_stall;
	assign job_valid = cnt_q != 2'd0;
	assign pop       = job_valid && job_take;
	assign job_data  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ design/xbrd_back.sv @@
// back part: generator, seeding, rejection and bit-serial modulo
`timescale 1ns / 1ps
module xbrd_back
	import xbrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr,
	input  logic [31:0] seed_val,
	input  logic        job_valid,
	output logic        job_take,
	input  job_t        job_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	typedef enum logic [8:0] {
		ST_SEED_ADD = 9'b000000001,
		ST_SEED_M1  = 9'b000000010,
		ST_SEED_M2  = 9'b000000100,
		ST_IDLE     = 9'b000001000,
		ST_DRAW_M   = 9'b000010000,
		ST_DRAW_R   = 9'b000100000,
		ST_LIM      = 9'b001000000,
		ST_DIV      = 9'b010000000,
		ST_DONE     = 9'b100000000
	} st_t;

	st_t         st_q;
	logic [63:0] s_q [4];
	logic [63:0] ctr_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [1:0]  mstep_q;
	logic [1:0]  fill_q;
	job_t        job_q;
	logic [63:0] word_q;
	logic [63:0] mul_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [6:0]  bit_q;
	logic        lim_q;     // computing limit remainder, else final modulo
	logic [63:0] limit_q;
	logic        ov_q;
	out_item_t   out_q;

	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	logic [63:0] z1;
	logic [63:0] z2;
	logic [63:0] rot;
	logic [63:0] t17;
	logic [63:0] n2;
	logic [63:0] n3;
	logic [63:0] quo;
	logic [63:0] mx;
	logic [63:0] mconst;
	logic [63:0] pp;
	logic [63:0] msum;
	logic        out_load;

	assign job_take  = (st_q == ST_IDLE) && job_valid;
	assign out_valid = ov_q;
	assign out_data  = out_q;
	assign out_load  = (st_q == ST_DONE) && !seed_wr && (!ov_q || !out_stall);

	// restoring division step, one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, dvd_q[63]};
		rem_sub = rem_sh - {1'b0, job_q.bound};
	end

	// splitmix multiply, one 16-bit slice of the constant per cycle
	always_comb begin
		mx     = (st_q == ST_SEED_M1) ? z2 : z1;
		mconst = (st_q == ST_SEED_M1) ? MIX_MUL_B : MIX_MUL_A;
		unique case (mstep_q)
			2'd0: pp = mx * {48'd0, mconst[15:0]};
			2'd1: pp = (mx * {48'd0, mconst[31:16]}) << 16;
			2'd2: pp = (mx * {48'd0, mconst[47:32]}) << 32;
			2'd3: pp = (mx * {48'd0, mconst[63:48]}) << 48;
		endcase
		msum = ((mstep_q == 2'd0) ? 64'd0 : acc_q) + pp;
	end

	assign z1  = ctr_q ^ (ctr_q >> 30);
	assign z2  = z_q ^ (z_q >> 27);
	assign rot = {mul_q[56:0], mul_q[63:57]};
	assign t17 = s_q[1] << 17;
	assign n2  = s_q[2] ^ s_q[0];
	assign n3  = s_q[3] ^ s_q[1];
	assign quo = rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_SEED_ADD: begin
				acc_q <= msum;
				if (mstep_q == 2'd3) begin
					z_q <= msum;
				end
			end
			ST_SEED_M1: begin
				acc_q <= msum;
				if (mstep_q == 2'd3) begin
					z_q <= msum;
				end
			end
			ST_SEED_M2: begin
				s_q[fill_q] <= z_q ^ (z_q >> 31);
			end
			ST_IDLE: begin
				job_q <= job_data;
				mul_q <= s_q[1] * 64'd5;
			end
			ST_DRAW_M: begin
				word_q <= rot * 64'd9;
				s_q[0] <= s_q[0] ^ n3;
				s_q[1] <= s_q[1] ^ n2;
				s_q[2] <= n2 ^ t17;
				s_q[3] <= {n3[18:0], n3[63:19]};
			end
			ST_DRAW_R: begin
				rem_q <= '0;
				dvd_q <= lim_q ? 64'hFFFFFFFFFFFFFFFF : word_q;
				bit_q <= 7'd0;
				mul_q <= s_q[1] * 64'd5;
			end
			ST_LIM: begin
				rem_q <= '0;
				dvd_q <= 64'hFFFFFFFFFFFFFFFF;
				bit_q <= 7'd0;
			end
			ST_DIV: begin
				rem_q <= quo;
				dvd_q <= {dvd_q[62:0], 1'b0};
				bit_q <= bit_q + 7'd1;
				mul_q <= s_q[1] * 64'd5;
				if (bit_q == 7'd63 && lim_q) begin
					limit_q <= 64'hFFFFFFFFFFFFFFFE - quo;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_SEED_ADD;
			ctr_q   <= GOLDEN_STEP;
			fill_q  <= 2'd0;
			mstep_q <= 2'd0;
			lim_q   <= 1'b0;
			ov_q    <= 1'b0;
			out_q   <= '0;
		end else begin
			ov_q <= out_load || (ov_q && out_stall);
			if (seed_wr) begin
				st_q    <= ST_SEED_ADD;
				ctr_q   <= {{32{seed_val[31]}}, seed_val} + GOLDEN_STEP;
				fill_q  <= 2'd0;
				mstep_q <= 2'd0;
			end else begin
				unique case (st_q)
					ST_SEED_ADD: begin
						mstep_q <= mstep_q + 2'd1;
						if (mstep_q == 2'd3) begin
							st_q <= ST_SEED_M1;
						end
					end
					ST_SEED_M1: begin
						mstep_q <= mstep_q + 2'd1;
						if (mstep_q == 2'd3) begin
							st_q <= ST_SEED_M2;
						end
					end
					ST_SEED_M2: begin
						ctr_q  <= ctr_q + GOLDEN_STEP;
						fill_q <= fill_q + 2'd1;
						st_q   <= (fill_q == 2'd3) ? ST_IDLE : ST_SEED_ADD;
					end
					ST_IDLE: begin
						if (job_take) begin
							if (!job_data.draw) begin
								st_q <= ST_DONE;
							end else if (job_data.bounded) begin
								lim_q <= 1'b1;
								st_q  <= ST_LIM;
							end else begin
								st_q <= ST_DRAW_M;
							end
						end
					end
					ST_LIM: st_q <= ST_DIV;
					ST_DRAW_M: st_q <= ST_DRAW_R;
					ST_DRAW_R: begin
						if (!job_q.bounded) begin
							st_q <= ST_DONE;
						end else if (word_q > limit_q) begin
							st_q <= ST_DRAW_M;
						end else begin
							st_q <= ST_DIV;
						end
					end
					ST_DIV: begin
						if (bit_q == 7'd63) begin
							if (lim_q) begin
								lim_q <= 1'b0;
								st_q  <= ST_DRAW_M;
							end else begin
								st_q <= ST_DONE;
							end
						end
					end
					ST_DONE: begin
						if (out_load) begin
							out_q.raw_word    <= job_q.draw ? word_q : 64'd0;
							out_q.invalid_arg <= job_q.bad;
							out_q.int_value   <= (job_q.bounded && !job_q.pct) ?
								job_q.offset + rem_q[31:0] : 32'd0;
							out_q.chance_hit  <= job_q.pct ?
								(rem_q[31:0] < job_q.pct_val) : job_q.hit;
							st_q <= ST_IDLE;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule
